// File: rtl/tapia_pkg.sv
package tapia_pkg;

    localparam int ARMS       = 6;
    localparam int WRENCH_LEN = 6;
    localparam int MAT_DEPTH  = 2 * ARMS * WRENCH_LEN;
    localparam int CORDIC_LAST = 26;

    localparam logic signed [35:0] PI_Q      = 36'sd210828714;
    localparam logic signed [35:0] TWO_PI_Q  = 36'sd421657428;
    localparam logic signed [31:0] HALF_PI_Q = 32'sd105414357;
    localparam logic [17:0]        THR_MAX   = 18'h3FFFF;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_LOAD,
        ST_SQC,
        ST_SQS,
        ST_NORM,
        ST_PRE,
        ST_CORDIC,
        ST_UNW1,
        ST_UNW2,
        ST_UNW3,
        ST_NEXT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       acc_clr;
        logic       wr_coef;
        logic       take_wrench;
        logic       mac_issue;
        logic       mac_half;
        logic [2:0] mac_col;
        logic [2:0] arm;
        logic       ld_vec;
        logic       sq_c;
        logic       sq_s;
        logic       norm_shift;
        logic       pre_rot;
        logic       cordic;
        logic [4:0] step;
        logic       unw1;
        logic       unw2;
        logic       unw3;
        logic       publish;
    } cmd_t;

    typedef struct packed {
        logic zero;
        logic norm_done;
        logic out_free;
    } status_t;

    // atan(2^-i) in Q.26; beyond the table it is 2^(26-i)
    function automatic logic signed [31:0] atan_val(input logic [4:0] i);
        logic signed [31:0] r;
        case (i)
            5'd0:    r = 32'sd52707179;
            5'd1:    r = 32'sd31114864;
            5'd2:    r = 32'sd16440240;
            5'd3:    r = 32'sd8345322;
            5'd4:    r = 32'sd4188855;
            5'd5:    r = 32'sd2096470;
            5'd6:    r = 32'sd1048491;
            5'd7:    r = 32'sd524277;
            5'd8:    r = 32'sd262143;
            5'd9:    r = 32'sd131072;
            default: r = 32'sd1 <<< (5'd26 - i);
        endcase
        return r;
    endfunction

endpackage

// File: rtl/tapia_ram.sv
module tapia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 72
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/tapia_ctrl.sv
module tapia_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                kind,
    input  tapia_pkg::status_t  status,
    output tapia_pkg::cmd_t     cmd,
    output logic                in_stall
);

    tapia_pkg::state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] arm_reg, arm_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tapia_pkg::ST_IDLE;
            cnt_reg   <= '0;
            arm_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            arm_reg   <= arm_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        arm_next   = arm_reg;
        case (state_reg)
            tapia_pkg::ST_IDLE:
            begin
                cnt_next = '0;
                arm_next = '0;
                if (in_valid && kind)
                begin
                    state_next = tapia_pkg::ST_MAC;
                end
            end
            tapia_pkg::ST_MAC:
            begin
                if (cnt_reg == 5'd11)
                begin
                    cnt_next   = '0;
                    state_next = tapia_pkg::ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            tapia_pkg::ST_DRAIN:
            begin
                if (cnt_reg == 5'd1)
                begin
                    cnt_next   = '0;
                    state_next = tapia_pkg::ST_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            tapia_pkg::ST_LOAD: state_next = tapia_pkg::ST_SQC;
            tapia_pkg::ST_SQC:  state_next = tapia_pkg::ST_SQS;
            tapia_pkg::ST_SQS:  state_next = tapia_pkg::ST_NORM;
            tapia_pkg::ST_NORM:
            begin
                if (status.zero)
                begin
                    state_next = tapia_pkg::ST_UNW1;
                end
                else if (status.norm_done)
                begin
                    state_next = tapia_pkg::ST_PRE;
                end
            end
            tapia_pkg::ST_PRE:
            begin
                cnt_next   = '0;
                state_next = tapia_pkg::ST_CORDIC;
            end
            tapia_pkg::ST_CORDIC:
            begin
                if (cnt_reg == 5'(tapia_pkg::CORDIC_LAST))
                begin
                    cnt_next   = '0;
                    state_next = tapia_pkg::ST_UNW1;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            tapia_pkg::ST_UNW1: state_next = tapia_pkg::ST_UNW2;
            tapia_pkg::ST_UNW2: state_next = tapia_pkg::ST_UNW3;
            tapia_pkg::ST_UNW3:
            begin
                if (arm_reg == 3'(tapia_pkg::ARMS - 1))
                begin
                    state_next = tapia_pkg::ST_DONE;
                end
                else
                begin
                    state_next = tapia_pkg::ST_NEXT;
                end
            end
            tapia_pkg::ST_NEXT:
            begin
                arm_next   = arm_reg + 3'd1;
                cnt_next   = '0;
                state_next = tapia_pkg::ST_MAC;
            end
            tapia_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = tapia_pkg::ST_IDLE;
                end
            end
            default: state_next = tapia_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.arm         = arm_reg;
        cmd.step        = cnt_reg;
        cmd.mac_half    = (cnt_reg > 5'd5);
        cmd.mac_col     = (cnt_reg > 5'd5) ? 3'(cnt_reg - 5'd6) : cnt_reg[2:0];
        in_stall        = 1'b1;
        case (state_reg)
            tapia_pkg::ST_IDLE:
            begin
                in_stall        = 1'b0;
                cmd.acc_clr     = 1'b1;
                cmd.wr_coef     = in_valid && !kind;
                cmd.take_wrench = in_valid && kind;
            end
            tapia_pkg::ST_MAC:    cmd.mac_issue  = 1'b1;
            tapia_pkg::ST_LOAD:   cmd.ld_vec     = 1'b1;
            tapia_pkg::ST_SQC:    cmd.sq_c       = 1'b1;
            tapia_pkg::ST_SQS:    cmd.sq_s       = 1'b1;
            tapia_pkg::ST_NORM:   cmd.norm_shift = !status.zero && !status.norm_done;
            tapia_pkg::ST_PRE:    cmd.pre_rot    = 1'b1;
            tapia_pkg::ST_CORDIC: cmd.cordic     = 1'b1;
            tapia_pkg::ST_UNW1:   cmd.unw1       = 1'b1;
            tapia_pkg::ST_UNW2:   cmd.unw2       = 1'b1;
            tapia_pkg::ST_UNW3:   cmd.unw3       = 1'b1;
            tapia_pkg::ST_NEXT:   cmd.acc_clr    = 1'b1;
            tapia_pkg::ST_DONE:   cmd.publish    = status.out_free;
            default:              cmd.acc_clr    = 1'b0;
        endcase
    end

endmodule

// File: rtl/tapia_datapath.sv
module tapia_datapath #(
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tapia_pkg::cmd_t     cmd,
    output tapia_pkg::status_t  status,
    input  logic signed [31:0]  force_x,
    input  logic signed [31:0]  force_y,
    input  logic signed [31:0]  force_z,
    input  logic signed [31:0]  torque_x,
    input  logic signed [31:0]  torque_y,
    input  logic signed [31:0]  torque_z,
    input  logic [6:0]          coef_index,
    input  logic signed [31:0]  coef_value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [17:0]         throttle_0,
    output logic [17:0]         throttle_1,
    output logic [17:0]         throttle_2,
    output logic [17:0]         throttle_3,
    output logic [17:0]         throttle_4,
    output logic [17:0]         throttle_5,
    output logic signed [31:0]  angle_0,
    output logic signed [31:0]  angle_1,
    output logic signed [31:0]  angle_2,
    output logic signed [31:0]  angle_3,
    output logic signed [31:0]  angle_4,
    output logic signed [31:0]  angle_5
);

    localparam int MAC_SHIFT = COEF_FRAC_BITS - 8;

    logic signed [31:0] w_reg [tapia_pkg::WRENCH_LEN];

    // coefficient store and multiply-accumulate
    logic [3:0]         row;
    logic [6:0]         rd_addr;
    logic [31:0]        ram_rdata;
    logic               v1_reg, v2_reg, half1_reg, half2_reg;
    logic signed [31:0] wsel_reg;
    logic signed [63:0] prod_reg, acc_c_reg, acc_s_reg, prod_sh;

    assign row     = cmd.mac_half ? (4'(cmd.arm) + 4'(tapia_pkg::ARMS)) : 4'(cmd.arm);
    assign rd_addr = (7'(row) << 2) + (7'(row) << 1) + 7'(cmd.mac_col);
    assign prod_sh = prod_reg >>> MAC_SHIFT;

    tapia_ram #(
        .WIDTH (32),
        .DEPTH (tapia_pkg::MAT_DEPTH)
    ) u_coef_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_coef && (coef_index < 7'(tapia_pkg::MAT_DEPTH))),
        .wr_addr (coef_index),
        .wr_data (coef_value),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_wrench)
        begin
            w_reg[0] <= force_x;
            w_reg[1] <= force_y;
            w_reg[2] <= force_z;
            w_reg[3] <= torque_x;
            w_reg[4] <= torque_y;
            w_reg[5] <= torque_z;
        end
        half1_reg <= cmd.mac_half;
        wsel_reg  <= w_reg[cmd.mac_col];
        half2_reg <= half1_reg;
        prod_reg  <= $signed(ram_rdata) * wsel_reg;
        if (cmd.acc_clr)
        begin
            acc_c_reg <= '0;
            acc_s_reg <= '0;
        end
        else if (v2_reg)
        begin
            if (half2_reg)
            begin
                acc_s_reg <= acc_s_reg + prod_sh;
            end
            else
            begin
                acc_c_reg <= acc_c_reg + prod_sh;
            end
        end
    end

    // magnitude and angle of one arm
    logic signed [63:0] x_reg, y_reg, xs, ys;
    logic signed [31:0] z_reg, at;
    logic [63:0]        ax, ay, am, acc_ac, acc_as;
    logic               big_reg, norm_big, norm_small;
    logic [53:0]        sqc_reg, n_reg, res_reg, sq_bit, trial;
    logic [5:0]         bit_pos;

    assign ax         = x_reg[63] ? 64'(-x_reg) : 64'(x_reg);
    assign ay         = y_reg[63] ? 64'(-y_reg) : 64'(y_reg);
    assign am         = (ax > ay) ? ax : ay;
    assign acc_ac     = acc_c_reg[63] ? 64'(-acc_c_reg) : 64'(acc_c_reg);
    assign acc_as     = acc_s_reg[63] ? 64'(-acc_s_reg) : 64'(acc_s_reg);
    assign norm_big   = |am[63:55];
    assign norm_small = !(|am[63:54]);

    assign status.zero      = (x_reg == '0) && (y_reg == '0);
    assign status.norm_done = !norm_big && !norm_small;
    assign status.out_free  = !out_valid || !out_stall;

    assign xs      = x_reg >>> cmd.step;
    assign ys      = y_reg >>> cmd.step;
    assign at      = tapia_pkg::atan_val(cmd.step);
    assign bit_pos = 6'd52 - {cmd.step, 1'b0};
    assign sq_bit  = 54'd1 << bit_pos;
    assign trial   = res_reg + sq_bit;

    always_ff @(posedge clk)
    begin
        if (cmd.ld_vec)
        begin
            x_reg   <= acc_c_reg;
            y_reg   <= acc_s_reg;
            z_reg   <= '0;
            res_reg <= '0;
            big_reg <= (|acc_ac[63:26]) || (|acc_as[63:26]);
        end
        else if (cmd.norm_shift)
        begin
            if (norm_big)
            begin
                x_reg <= x_reg >>> 1;
                y_reg <= y_reg >>> 1;
            end
            else
            begin
                x_reg <= x_reg <<< 1;
                y_reg <= y_reg <<< 1;
            end
        end
        else if (cmd.pre_rot && x_reg[63])
        begin
            if (!y_reg[63])
            begin
                x_reg <= y_reg;
                y_reg <= -x_reg;
                z_reg <= tapia_pkg::HALF_PI_Q;
            end
            else
            begin
                x_reg <= -y_reg;
                y_reg <= x_reg;
                z_reg <= -tapia_pkg::HALF_PI_Q;
            end
        end
        else if (cmd.cordic)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
            // square root runs alongside, digit by digit
            if (n_reg >= trial)
            begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + sq_bit;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
        if (cmd.sq_c)
        begin
            sqc_reg <= ax[26:0] * ax[26:0];
        end
        if (cmd.sq_s)
        begin
            n_reg <= sqc_reg + 54'(ay[26:0] * ay[26:0]);
        end
    end

    // unwrap next to the previous angle
    logic signed [31:0] prev_reg [tapia_pkg::ARMS];
    logic [17:0]        thr_reg  [tapia_pkg::ARMS];
    logic signed [31:0] prev_sel, a_sat;
    logic signed [32:0] prev_ext;
    logic [32:0]        prev_mag, qv;
    logic [2:0]         q;
    logic signed [35:0] qterm, a_reg, d1, d2, a3, prev36;
    logic [27:0]        rnd;
    logic [17:0]        thr_val;

    assign prev_sel = prev_reg[cmd.arm];
    assign prev_ext = {prev_sel[31], prev_sel};
    assign prev36   = 36'(prev_sel);
    assign prev_mag = prev_ext[32] ? 33'(-prev_ext) : 33'(prev_ext);
    assign qv       = prev_mag + 33'(tapia_pkg::PI_Q);
    assign q        = 3'(qv >= 33'd421657428) + 3'(qv >= 33'd843314856)
                    + 3'(qv >= 33'd1264972284) + 3'(qv >= 33'd1686629712)
                    + 3'(qv >= 33'd2108287140);

    always_comb
    begin
        case (q)
            3'd0:    qterm = '0;
            3'd1:    qterm = 36'sd421657428;
            3'd2:    qterm = 36'sd843314856;
            3'd3:    qterm = 36'sd1264972284;
            3'd4:    qterm = 36'sd1686629712;
            3'd5:    qterm = 36'sd2108287140;
            default: qterm = '0;
        endcase
    end

    assign d1  = a_reg - prev36;
    assign d2  = a_reg - prev36;
    assign a3  = (d2 < -tapia_pkg::PI_Q) ? (a_reg + tapia_pkg::TWO_PI_Q) : a_reg;
    assign a_sat = (a3 > 36'sd2147483647)  ? 32'sh7FFFFFFF :
                   (a3 < -36'sd2147483648) ? 32'sh80000000 : a3[31:0];

    assign rnd     = 28'(res_reg[26:0]) + 28'd128;
    assign thr_val = big_reg ? tapia_pkg::THR_MAX :
                     (|rnd[27:26]) ? tapia_pkg::THR_MAX : rnd[25:8];

    always_ff @(posedge clk)
    begin
        if (cmd.unw1)
        begin
            a_reg <= 36'(z_reg) + (prev_sel[31] ? -qterm : qterm);
        end
        else if (cmd.unw2 && (d1 > tapia_pkg::PI_Q))
        begin
            a_reg <= a_reg - tapia_pkg::TWO_PI_Q;
        end
        if (cmd.unw3)
        begin
            thr_reg[cmd.arm] <= thr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tapia_pkg::ARMS; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else if (cmd.unw3)
        begin
            prev_reg[cmd.arm] <= a_sat;
        end
    end

    // output register
    logic        out_valid_reg;
    logic [17:0] out_thr_reg [tapia_pkg::ARMS];
    logic signed [31:0] out_ang_reg [tapia_pkg::ARMS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            for (int i = 0; i < tapia_pkg::ARMS; i++)
            begin
                out_thr_reg[i] <= thr_reg[i];
                out_ang_reg[i] <= prev_reg[i];
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign throttle_0 = out_thr_reg[0];
    assign throttle_1 = out_thr_reg[1];
    assign throttle_2 = out_thr_reg[2];
    assign throttle_3 = out_thr_reg[3];
    assign throttle_4 = out_thr_reg[4];
    assign throttle_5 = out_thr_reg[5];
    assign angle_0    = out_ang_reg[0];
    assign angle_1    = out_ang_reg[1];
    assign angle_2    = out_ang_reg[2];
    assign angle_3    = out_ang_reg[3];
    assign angle_4    = out_ang_reg[4];
    assign angle_5    = out_ang_reg[5];

endmodule

// File: rtl/tilt_arm_pseudo_inverse_allocation.sv
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   kind, force_*, torque_*, coef_index, coef_value
// out      output     out_valid/out_stall throttle_0..5, angle_0..5
//
// Load request: taken while idle, no result.
// Wrench request: per arm 12 MACs plus a drain, load and square, normalise, pre-rotate,
// 27 CORDIC/sqrt steps, unwrap, and a step to the next arm between arms (a zero vector
// skips pre-rotate and CORDIC), for 6 arms, then the result is published.
// Input stalls from a wrench's acceptance until its result sits in the output register.
// Reset clears previous angles and control; the coefficient store is not cleared.
// A pending result may stay stalled while load requests keep going in.
module tilt_arm_pseudo_inverse_allocation #(
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic signed [31:0] force_x,
    input  logic signed [31:0] force_y,
    input  logic signed [31:0] force_z,
    input  logic signed [31:0] torque_x,
    input  logic signed [31:0] torque_y,
    input  logic signed [31:0] torque_z,
    input  logic [6:0]         coef_index,
    input  logic signed [31:0] coef_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [17:0]        throttle_0,
    output logic [17:0]        throttle_1,
    output logic [17:0]        throttle_2,
    output logic [17:0]        throttle_3,
    output logic [17:0]        throttle_4,
    output logic [17:0]        throttle_5,
    output logic signed [31:0] angle_0,
    output logic signed [31:0] angle_1,
    output logic signed [31:0] angle_2,
    output logic signed [31:0] angle_3,
    output logic signed [31:0] angle_4,
    output logic signed [31:0] angle_5
);

    tapia_pkg::cmd_t    cmd;
    tapia_pkg::status_t status;

    tapia_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    tapia_datapath #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .force_x    (force_x),
        .force_y    (force_y),
        .force_z    (force_z),
        .torque_x   (torque_x),
        .torque_y   (torque_y),
        .torque_z   (torque_z),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .throttle_0 (throttle_0),
        .throttle_1 (throttle_1),
        .throttle_2 (throttle_2),
        .throttle_3 (throttle_3),
        .throttle_4 (throttle_4),
        .throttle_5 (throttle_5),
        .angle_0    (angle_0),
        .angle_1    (angle_1),
        .angle_2    (angle_2),
        .angle_3    (angle_3),
        .angle_4    (angle_4),
        .angle_5    (angle_5)
    );

    a_wrench_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && kind) |=> in_stall)
        else $error("wrench accepted but input not held off");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !kind && !out_valid) |=> !out_valid)
        else $error("load request produced a result");

    a_publish_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a wrench in progress");

endmodule

// File: verif/tilt_arm_pseudo_inverse_allocation_tb.sv
module tilt_arm_pseudo_inverse_allocation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 24;
    localparam int WATCHDOG = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic kind = 1'b0;
    logic signed [31:0] force_x = '0, force_y = '0, force_z = '0;
    logic signed [31:0] torque_x = '0, torque_y = '0, torque_z = '0;
    logic [6:0] coef_index = '0;
    logic signed [31:0] coef_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [17:0] throttle_0, throttle_1, throttle_2, throttle_3, throttle_4, throttle_5;
    logic signed [31:0] angle_0, angle_1, angle_2, angle_3, angle_4, angle_5;

    tilt_arm_pseudo_inverse_allocation #(.COEF_FRAC_BITS(FRAC)) dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    typedef struct {
        logic [17:0] thr [tapia_pkg::ARMS];
        logic signed [31:0] ang [tapia_pkg::ARMS];
    } alloc_t;

    alloc_t expected_q[$];
    logic signed [31:0] coef_mem [tapia_pkg::MAT_DEPTH];
    logic signed [31:0] prev_ang [tapia_pkg::ARMS];
    int mismatches = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int timed_out = 0;
    int wrenches_sent = 0;
    int loads_sent = 0;
    int out_wait = 0;
    bit stall_on = 1'b1;
    bit bus_busy = 1'b0;

    function automatic longint asr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint root(longint n);
        longint r = 0;
        longint b = 64'sd1 <<< 62;
        while (b > n)
            b = b >>> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint tilt_of(longint s, longint c);
        longint x = c, y = s, z = 0, m, t, a, xs, ys;
        if (x == 0 && y == 0)
            return 0;
        m = mag(x) > mag(y) ? mag(x) : mag(y);
        while (m >= (64'sd1 <<< 55))
        begin
            x = x >>> 1;
            y = y >>> 1;
            m = mag(x) > mag(y) ? mag(x) : mag(y);
        end
        while (m < (64'sd1 <<< 54))
        begin
            x = x <<< 1;
            y = y <<< 1;
            m = mag(x) > mag(y) ? mag(x) : mag(y);
        end
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = tapia_pkg::HALF_PI_Q;
            end
            else
            begin
                x = -y; y = t; z = -tapia_pkg::HALF_PI_Q;
            end
        end
        for (int i = 0; i <= tapia_pkg::CORDIC_LAST; i++)
        begin
            case (i)
                0: a = 52707179;
                1: a = 31114864;
                2: a = 16440240;
                3: a = 8345322;
                4: a = 4188855;
                5: a = 2096470;
                6: a = 1048491;
                7: a = 524277;
                8: a = 262143;
                9: a = 131072;
                default: a = 64'sd1 <<< (26 - i);
            endcase
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys; y -= xs; z += a;
            end
            else
            begin
                x -= ys; y += xs; z -= a;
            end
        end
        return z;
    endfunction

    function automatic longint unwrap_near(longint a, longint p);
        longint pi = tapia_pkg::PI_Q, tp = tapia_pkg::TWO_PI_Q;
        longint q = (mag(p) + pi) / tp;
        if (p < 0)
            q = -q;
        a += q * tp;
        if (a - p > pi)
            a -= tp;
        if (a - p < -pi)
            a += tp;
        if (a > 64'sd2147483647)
            a = 64'sd2147483647;
        if (a < -64'sd2147483648)
            a = -64'sd2147483648;
        return a;
    endfunction

    function automatic alloc_t allocate(longint w [tapia_pkg::WRENCH_LEN]);
        alloc_t res;
        longint cs [2*tapia_pkg::ARMS];
        longint c, s, thr, ang;
        for (int r = 0; r < 2*tapia_pkg::ARMS; r++)
        begin
            cs[r] = 0;
            for (int k = 0; k < tapia_pkg::WRENCH_LEN; k++)
                cs[r] += asr(w[k] * longint'(coef_mem[r*tapia_pkg::WRENCH_LEN+k]), FRAC - 8);
        end
        for (int arm = 0; arm < tapia_pkg::ARMS; arm++)
        begin
            c = cs[arm];
            s = cs[tapia_pkg::ARMS+arm];
            if (mag(c) >= (64'sd1 <<< 26) || mag(s) >= (64'sd1 <<< 26))
                thr = tapia_pkg::THR_MAX;
            else
            begin
                thr = (root(c*c + s*s) + 128) >>> 8;
                if (thr > tapia_pkg::THR_MAX)
                    thr = tapia_pkg::THR_MAX;
            end
            ang = unwrap_near(tilt_of(s, c), prev_ang[arm]);
            prev_ang[arm] = ang[31:0];
            res.thr[arm] = thr[17:0];
            res.ang[arm] = ang[31:0];
        end
        return res;
    endfunction

    // drops valid once the last request has gone and nothing follows straight away
    task automatic idle_bus();
        if (bus_busy)
        begin
            in_valid <= 1'b0;
            bus_busy = 1'b0;
        end
    endtask

    // drives one request and holds it until taken
    task automatic send(bit k, logic signed [31:0] f [tapia_pkg::WRENCH_LEN], logic [6:0] idx,
                        logic signed [31:0] val, bit gaps);
        longint w [tapia_pkg::WRENCH_LEN];
        int g;
        g = 0;
        if (gaps)
            g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (g != 0)
        begin
            idle_bus();
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        bus_busy = 1'b1;
        kind <= k;
        force_x <= f[0]; force_y <= f[1]; force_z <= f[2];
        torque_x <= f[3]; torque_y <= f[4]; torque_z <= f[5];
        coef_index <= idx;
        coef_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (k)
        begin
            for (int i = 0; i < tapia_pkg::WRENCH_LEN; i++)
                w[i] = f[i];
            expected_q.push_back(allocate(w));
            wrenches_sent++;
        end
        else
        begin
            if (idx < tapia_pkg::MAT_DEPTH)
                coef_mem[idx] = val;
            loads_sent++;
        end
    endtask

    function automatic logic signed [31:0] rand_word(int style);
        case (style)
            0: return $urandom;
            1: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
            2: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
            default: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
        endcase
    endfunction

    task automatic load_matrix(int style, bit gaps);
        logic signed [31:0] f [tapia_pkg::WRENCH_LEN];
        for (int i = 0; i < tapia_pkg::WRENCH_LEN; i++)
            f[i] = $urandom;
        for (int i = 0; i < tapia_pkg::MAT_DEPTH; i++)
            send(1'b0, f, i[6:0], rand_word(style), gaps);
    endtask

    task automatic send_wrench(int style, bit gaps);
        logic signed [31:0] f [tapia_pkg::WRENCH_LEN];
        for (int i = 0; i < tapia_pkg::WRENCH_LEN; i++)
            f[i] = rand_word(style);
        send(1'b1, f, 7'($urandom), $urandom, gaps);
    endtask

    task automatic drain();
        idle_bus();
        @(posedge clk);
        while (expected_q.size() != 0 && !timed_out)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic signed [31:0] f [tapia_pkg::WRENCH_LEN];
        load_matrix(2, 1'b0);
        foreach (f[i]) f[i] = '0;
        send(1'b1, f, 7'h7F, 32'sh7FFFFFFF, 1'b0);     // zero wrench
        foreach (f[i]) f[i] = 32'sh7FFFFFFF;
        send(1'b1, f, '0, '0, 1'b0);
        foreach (f[i]) f[i] = 32'sh80000000;
        send(1'b1, f, '0, '0, 1'b0);
        foreach (f[i]) f[i] = 32'sh00010000;
        send(1'b1, f, '0, '0, 1'b0);
        // out-of-range indices must be dropped
        send(1'b0, f, 7'd72, 32'sh80000000, 1'b0);
        send(1'b0, f, 7'h7F, 32'sh7FFFFFFF, 1'b0);
        foreach (f[i]) f[i] = 32'shFFFF0000;
        send(1'b1, f, '0, '0, 1'b0);
        drain();
    endtask

    // spins the angle one way so the unwrap walks across many turns and saturates
    task automatic test_winding();
        logic signed [31:0] f [tapia_pkg::WRENCH_LEN];
        foreach (f[i]) f[i] = '0;
        for (int i = 0; i < tapia_pkg::MAT_DEPTH; i++)
            send(1'b0, f, i[6:0], (i < 36) ? ((i % 6 == 0) ? 32'sh01000000 : '0)
                                 : ((i % 6 == 1) ? 32'sh01000000 : '0), 1'b0);
        for (int n = 0; n < 200; n++)
        begin
            foreach (f[i]) f[i] = '0;
            case (n % 3)
                0: begin f[0] = 32'sh00010000; end
                1: begin f[0] = -32'sh00008000; f[1] = 32'sh0000DDB4; end
                default: begin f[0] = -32'sh00008000; f[1] = -32'sh0000DDB4; end
            endcase
            send(1'b1, f, '0, '0, n > 150);
        end
        drain();
    endtask

    task automatic test_random(int total);
        int style;
        for (int n = 0; n < total; n++)
        begin
            if (n % 300 == 0)
            begin
                drain();
                repeat (400) @(posedge clk);
                load_matrix($urandom_range(0, 3), 1'b1);
            end
            else
            begin
                style = $urandom_range(0, 3);
                if ($urandom_range(0, 9) == 0)
                    send(1'b0, '{default: 32'sh0}, 7'($urandom_range(0, 127)),
                         rand_word(style), 1'b1);
                else
                    send_wrench(style, n % 200 > 120 ? 1'b0 : 1'b1);
            end
            if (n == total / 2)
            begin
                drain();
                stall_on = 1'b0;
            end
            if (n == 3 * total / 4)
                stall_on = 1'b1;
        end
        drain();
    endtask

    // result checker
    always @(posedge clk)
    begin
        alloc_t e;
        logic [17:0] gt [tapia_pkg::ARMS];
        logic signed [31:0] ga [tapia_pkg::ARMS];
        if (out_valid && !out_stall)
        begin
            gt = '{throttle_0, throttle_1, throttle_2, throttle_3, throttle_4, throttle_5};
            ga = '{angle_0, angle_1, angle_2, angle_3, angle_4, angle_5};
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at %0t", $realtime);
            end
            else
            begin
                e = expected_q.pop_front();
                for (int a = 0; a < tapia_pkg::ARMS; a++)
                begin
                    if (gt[a] !== e.thr[a])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d throttle_%0d: exp %0d got %0d",
                                     results_seen, a, e.thr[a], gt[a]);
                    end
                    if (ga[a] !== e.ang[a])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d angle_%0d: exp %0d got %0d",
                                     results_seen, a, e.ang[a], ga[a]);
                    end
                end
            end
        end
    end

    // receiver draws a fresh wait for each result
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            out_wait = $urandom_range(0, 19);
        else if (out_valid && out_wait > 0)
            out_wait = out_wait - 1;
        out_stall <= stall_on && (out_wait != 0);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out)
        begin
            timed_out = 1;
            $display("watchdog: no progress");
            $display("** tilt_arm_pseudo_inverse_allocation: FAILED **");
            $finish;
        end
    end

    initial
    begin
        foreach (coef_mem[i]) coef_mem[i] = '0;
        foreach (prev_ang[i]) prev_ang[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_winding();
        test_random(1200);
        repeat (100) @(posedge clk);
        $display("covered %0d wrenches and %0d coefficient loads, %0d results checked",
                 wrenches_sent, loads_sent, results_seen);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("** tilt_arm_pseudo_inverse_allocation: PASSED **");
        else
            $display("** tilt_arm_pseudo_inverse_allocation: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
rtl/tapia_pkg.sv
rtl/tapia_ram.sv
rtl/tapia_ctrl.sv
rtl/tapia_datapath.sv
rtl/tilt_arm_pseudo_inverse_allocation.sv
verif/tilt_arm_pseudo_inverse_allocation_tb.sv
